// ----- rtl/core/tmau_pkg.sv -----
package tmau_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_SAFETY_MARGIN = 3'd0;
    localparam logic [2:0] REG_CRUISE_SPEED  = 3'd1;
    localparam logic [2:0] REG_ACCEPT_PCT    = 3'd2;
    localparam logic [2:0] REG_OVERSPEED_PCT = 3'd3;
    localparam logic [2:0] REG_STATION_HERE  = 3'd4;
    localparam logic [2:0] REG_STATION_NEXT  = 3'd5;
    localparam logic [2:0] REG_LAST_STATION  = 3'd6;

    // Operation codes
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Results per send tick
    localparam int MAX_RESULTS = 32;
    localparam int RES_CNT_W   = 6;

    // Speed classes
    localparam logic [1:0] SPD_OK     = 2'd0;
    localparam logic [1:0] SPD_ADJUST = 2'd1;
    localparam logic [1:0] SPD_DANGER = 2'd2;

    // One stored train status
    typedef struct packed {
        logic [7:0]  id;
        logic [23:0] pos;
        logic [15:0] spd;
        logic [15:0] len;
        logic [15:0] stop;
        logic        cru;
    } entry_t;

    // Speed band limits, scaled by 100
    typedef struct packed {
        logic signed [25:0] lo;
        logic signed [25:0] hi;
        logic signed [25:0] ov;
    } band_t;

endpackage

// ----- rtl/core/train_movement_authority_unit.sv -----
// Movement authority unit. A store request goes into its table unless that table is
// full, and busy stays low, so reports may come every cycle. A send tick raises
// busy and walks each table by repeated scans of the status memory (one entry
// read per cycle): a table of n trains needs n+1 passes, each a scan state per
// entry, then a wait and a decide state. One result appears per train, each valid
// for exactly one cycle on result_valid; the receiver cannot stall it, so it must
// take every result as it comes. A tick with both tables empty gives no result.
// At most 32 results per tick; last marks the final one.
module train_movement_authority_unit #(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               op,
    input  logic [7:0]         train_id,
    input  logic [23:0]        position,
    input  logic [15:0]        speed,
    input  logic [15:0]        train_length,
    input  logic [15:0]        stop_distance,
    input  logic               cruising,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    output logic               result_valid,
    output logic [7:0]         receiver_id,
    output logic signed [24:0] authority_limit,
    output logic               end_of_track,
    output logic               emergency_brake,
    output logic               adjust_speed,
    output logic [15:0]        desired_speed,
    output logic               after_station,
    output logic [15:0]        brake_count,
    output logic               last
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = 24 + IW;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    // Configuration registers
    logic [15:0] margin_reg;
    logic [15:0] cruise_reg;
    logic [6:0]  acc_pct_reg;
    logic [6:0]  ovr_pct_reg;
    logic [23:0] here_reg;
    logic [23:0] next_reg;
    logic        last_st_reg;

    // Status memory: both tables, table select in the top address bit
    tmau_pkg::entry_t mem [2**(IW+1)];
    tmau_pkg::entry_t rdata_reg;

    logic [CW-1:0] bcnt_reg;
    logic [CW-1:0] acnt_reg;
    logic [15:0]   btotal_reg;

    logic [1:0]    state_reg;
    logic          tbl_reg;
    logic [CW-1:0] rd_reg;
    logic          rdv_reg;
    logic [IW-1:0] rdidx_reg;

    tmau_pkg::entry_t cur_reg;
    logic [IW-1:0]    curidx_reg;
    logic             have_cur_reg;
    tmau_pkg::entry_t best_reg;
    logic [IW-1:0]    bestidx_reg;
    logic             best_valid_reg;
    logic [tmau_pkg::RES_CNT_W-1:0] emit_cnt_reg;

    tmau_pkg::band_t band_reg;
    logic [1:0]      spd_class;

    logic             accept;
    logic             sel_after;
    logic [CW-1:0]    n_cur;
    logic [KW-1:0]    rd_key;
    logic [KW-1:0]    cur_key;
    logic [KW-1:0]    best_key;
    logic             take;
    tmau_pkg::entry_t in_entry;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign sel_after = (position >= here_reg);
    assign n_cur     = tbl_reg ? acnt_reg : bcnt_reg;

    assign in_entry = '{id: train_id, pos: position, spd: speed, len: train_length,
                        stop: stop_distance, cru: cruising};

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg  <= 16'd160;
            cruise_reg  <= 16'd5120;
            acc_pct_reg <= 7'd5;
            ovr_pct_reg <= 7'd10;
            here_reg    <= 24'd0;
            next_reg    <= 24'd0;
            last_st_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tmau_pkg::REG_SAFETY_MARGIN: margin_reg  <= cfg_data[15:0];
                tmau_pkg::REG_CRUISE_SPEED:  cruise_reg  <= cfg_data[15:0];
                tmau_pkg::REG_ACCEPT_PCT:    acc_pct_reg <= cfg_data[6:0];
                tmau_pkg::REG_OVERSPEED_PCT: ovr_pct_reg <= cfg_data[6:0];
                tmau_pkg::REG_STATION_HERE:  here_reg    <= cfg_data;
                tmau_pkg::REG_STATION_NEXT:  next_reg    <= cfg_data;
                tmau_pkg::REG_LAST_STATION:  last_st_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Precompute the speed band from the configuration
    always_ff @(posedge clk)
    begin
        band_reg.lo <= 26'($signed({10'd0, cruise_reg})
                       * $signed(9'd100 - {2'b00, acc_pct_reg}));
        band_reg.hi <= 26'($signed({10'd0, cruise_reg})
                       * $signed(9'd100 + {2'b00, acc_pct_reg}));
        band_reg.ov <= 26'($signed({10'd0, cruise_reg})
                       * $signed(9'd100 + {2'b00, ovr_pct_reg}));
    end

    // Store writes and scan reads
    always_ff @(posedge clk)
    begin
        if (accept && op == tmau_pkg::OP_STORE)
        begin
            if (sel_after && acnt_reg < CW'(TABLE_DEPTH))
            begin
                mem[{1'b1, acnt_reg[IW-1:0]}] <= in_entry;
            end
            else if (!sel_after && bcnt_reg < CW'(TABLE_DEPTH))
            begin
                mem[{1'b0, bcnt_reg[IW-1:0]}] <= in_entry;
            end
        end
        rdata_reg <= mem[{tbl_reg, rd_reg[IW-1:0]}];
    end

    // Successor search key: position, then arrival order
    assign rd_key   = {rdata_reg.pos, rdidx_reg};
    assign cur_key  = {cur_reg.pos, curidx_reg};
    assign best_key = {best_reg.pos, bestidx_reg};
    assign take     = rdv_reg && (!have_cur_reg || rd_key > cur_key)
                      && (!best_valid_reg || rd_key < best_key);

    tmau_speed_class u_speed_class
    (
        .spd       (cur_reg.spd),
        .cru       (cur_reg.cru),
        .band      (band_reg),
        .spd_class (spd_class)
    );

    // Result for the current train
    logic signed [25:0] spacing;
    logic signed [25:0] lim_gap;
    logic               gap_brake;
    logic               spd_brake;
    logic               furthest;
    logic               emit;
    logic               res_last;
    logic               cap_hit;

    assign spacing   = $signed({2'b00, best_reg.pos}) - $signed({2'b00, cur_reg.pos})
                       - $signed({10'd0, best_reg.len});
    assign lim_gap   = $signed({2'b00, best_reg.pos}) - $signed({10'd0, best_reg.len})
                       - $signed({10'd0, margin_reg});
    assign gap_brake = spacing <= $signed({9'd0, {1'b0, cur_reg.stop} + {1'b0, margin_reg}});
    assign spd_brake = (spd_class == tmau_pkg::SPD_DANGER);
    assign furthest  = !best_valid_reg;
    assign emit      = (state_reg == ST_DECIDE) && have_cur_reg;
    assign cap_hit   = (emit_cnt_reg == tmau_pkg::RES_CNT_W'(tmau_pkg::MAX_RESULTS - 1));
    assign res_last  = cap_hit || (furthest && (tbl_reg || acnt_reg == '0));

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bcnt_reg       <= '0;
            acnt_reg       <= '0;
            btotal_reg     <= '0;
            tbl_reg        <= 1'b0;
            rd_reg         <= '0;
            rdv_reg        <= 1'b0;
            have_cur_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
            emit_cnt_reg   <= '0;
            result_valid   <= 1'b0;
        end
        else
        begin
            rdv_reg      <= (state_reg == ST_SCAN);
            result_valid <= 1'b0;
            if (take)
            begin
                best_valid_reg <= 1'b1;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && op == tmau_pkg::OP_STORE)
                    begin
                        if (sel_after && acnt_reg < CW'(TABLE_DEPTH))
                        begin
                            acnt_reg <= acnt_reg + 1'b1;
                        end
                        else if (!sel_after && bcnt_reg < CW'(TABLE_DEPTH))
                        begin
                            bcnt_reg <= bcnt_reg + 1'b1;
                        end
                    end
                    else if (accept)
                    begin
                        emit_cnt_reg   <= '0;
                        have_cur_reg   <= 1'b0;
                        best_valid_reg <= 1'b0;
                        rd_reg         <= '0;
                        if (bcnt_reg != '0)
                        begin
                            tbl_reg   <= 1'b0;
                            state_reg <= ST_SCAN;
                        end
                        else if (acnt_reg != '0)
                        begin
                            tbl_reg   <= 1'b1;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (rd_reg == n_cur - 1'b1)
                    begin
                        state_reg <= ST_WAIT;
                    end
                    else
                    begin
                        rd_reg <= rd_reg + 1'b1;
                    end
                end
                ST_WAIT:
                begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    // Advance to the successor, or close the table
                    rd_reg         <= '0;
                    best_valid_reg <= 1'b0;
                    if (emit)
                    begin
                        result_valid <= 1'b1;
                        emit_cnt_reg <= emit_cnt_reg + 1'b1;
                        btotal_reg   <= btotal_reg + 16'(!furthest && gap_brake)
                                        + 16'(spd_brake);
                    end
                    if (!furthest)
                    begin
                        have_cur_reg <= 1'b1;
                        state_reg    <= (emit && cap_hit) ? ST_IDLE : ST_SCAN;
                    end
                    else if (!tbl_reg && acnt_reg != '0 && !cap_hit)
                    begin
                        tbl_reg      <= 1'b1;
                        have_cur_reg <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                    if (furthest || (emit && cap_hit))
                    begin
                        if (tbl_reg || acnt_reg == '0 || (emit && cap_hit))
                        begin
                            bcnt_reg <= '0;
                            acnt_reg <= '0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Track current and best entries
    always_ff @(posedge clk)
    begin
        rdidx_reg <= rd_reg[IW-1:0];
        if (take)
        begin
            best_reg    <= rdata_reg;
            bestidx_reg <= rdidx_reg;
        end
        if (state_reg == ST_DECIDE && !furthest)
        begin
            cur_reg    <= best_reg;
            curidx_reg <= bestidx_reg;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            receiver_id     <= cur_reg.id;
            end_of_track    <= furthest && tbl_reg && last_st_reg;
            emergency_brake <= (!furthest && gap_brake) || spd_brake;
            adjust_speed    <= (spd_class == tmau_pkg::SPD_ADJUST);
            desired_speed   <= (spd_class == tmau_pkg::SPD_ADJUST) ? cruise_reg : 16'd0;
            after_station   <= tbl_reg;
            brake_count     <= btotal_reg + 16'(!furthest && gap_brake) + 16'(spd_brake);
            last            <= res_last;
            if (!furthest)
            begin
                authority_limit <= lim_gap[24:0];
            end
            else if (!tbl_reg)
            begin
                authority_limit <= $signed({1'b0, here_reg});
            end
            else if (last_st_reg)
            begin
                authority_limit <= -25'sd1;
            end
            else
            begin
                authority_limit <= $signed({1'b0, next_reg});
            end
        end
    end

endmodule

// ----- rtl/core/tmau_speed_class.sv -----
module tmau_speed_class
(
    input  logic [15:0]     spd,
    input  logic            cru,
    input  tmau_pkg::band_t band,
    output logic [1:0]      spd_class
);

    logic signed [25:0] scaled;

    // Scale speed by 100 with shifts: 64 + 32 + 4
    assign scaled = $signed({2'b00, ({8'd0, spd} << 6) + ({8'd0, spd} << 5)
                                   + ({8'd0, spd} << 2)});

    // Classify against the band
    always_comb
    begin
        if (!cru)
        begin
            spd_class = tmau_pkg::SPD_OK;
        end
        else if (scaled < band.lo)
        begin
            spd_class = tmau_pkg::SPD_ADJUST;
        end
        else if (scaled <= band.hi)
        begin
            spd_class = tmau_pkg::SPD_OK;
        end
        else if (scaled < band.ov)
        begin
            spd_class = tmau_pkg::SPD_ADJUST;
        end
        else
        begin
            spd_class = tmau_pkg::SPD_DANGER;
        end
    end

endmodule
